// File: sv/bpc_pkg.sv
// shared types, codes and widths for the button press classifier
package bpc_pkg;

  localparam int NUM_BUTTONS_DEF = 4;

  localparam int SEL_W  = 2;
  localparam int NOW_W  = 32;
  localparam int CFG_W  = 16;
  localparam int EV_W   = 3;
  localparam int PH_W   = 3;
  localparam int CNT_W  = 2;
  localparam int CFG_IDX_W = 2;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;

  // per-button phase codes
  localparam logic [PH_W-1:0] PH_IDLE     = 3'd0;
  localparam logic [PH_W-1:0] PH_DEBOUNCE = 3'd1;
  localparam logic [PH_W-1:0] PH_PRESSED  = 3'd2;
  localparam logic [PH_W-1:0] PH_SHORT    = 3'd3;
  localparam logic [PH_W-1:0] PH_LONG     = 3'd4;
  localparam logic [PH_W-1:0] PH_LONG_REL = 3'd5;
  localparam logic [PH_W-1:0] PH_SINGLE   = 3'd6;
  localparam logic [PH_W-1:0] PH_DOUBLE   = 3'd7;

  // event codes
  localparam logic [EV_W-1:0] EV_NONE     = 3'd0;
  localparam logic [EV_W-1:0] EV_SINGLE   = 3'd1;
  localparam logic [EV_W-1:0] EV_DOUBLE   = 3'd2;
  localparam logic [EV_W-1:0] EV_LONG     = 3'd3;
  localparam logic [EV_W-1:0] EV_LONG_REL = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_GAP = 2'd2;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd50;
  localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd1000;
  localparam logic [CFG_W-1:0] DOUBLE_GAP_RST = 16'd400;

  localparam logic [CNT_W-1:0] CNT_MAX = 2'd3;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] long_press_ms;
    logic [CFG_W-1:0] double_gap_ms;
  } cfg_t;

  typedef struct packed {
    logic [PH_W-1:0]  phase;
    logic [NOW_W-1:0] phase_start;
    logic [NOW_W-1:0] hold_start;
    logic [CNT_W-1:0] press_count;
  } btn_state_t;

endpackage

// File: sv/bpc_cfg.sv
// configuration registers for thresholds
module bpc_cfg import bpc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0]     wr_data,
  output cfg_t                 cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        REG_DEBOUNCE:   cfg_nxt.debounce_ms   = wr_data;
        REG_LONG_PRESS: cfg_nxt.long_press_ms = wr_data;
        REG_DOUBLE_GAP: cfg_nxt.double_gap_ms = wr_data;
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms   <= DEBOUNCE_RST;
      cfg_r.long_press_ms <= LONG_PRESS_RST;
      cfg_r.double_gap_ms <= DOUBLE_GAP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: sv/bpc_step.sv
// next-state and event logic for one poll of one button
module bpc_step import bpc_pkg::*; (
  input  btn_state_t       cur,
  input  logic             pressed,
  input  logic [NOW_W-1:0] now_ms,
  input  cfg_t             cfg,
  output btn_state_t       nxt,
  output logic [EV_W-1:0]  event_code
);

  logic [NOW_W-1:0] since_phase;
  logic [NOW_W-1:0] since_hold;
  logic             gt_debounce;
  logic             gt_long;
  logic             gt_gap;

  // elapsed times wrap modulo 2^32
  assign since_phase = now_ms - cur.phase_start;
  assign since_hold  = now_ms - cur.hold_start;
  assign gt_debounce = since_phase > NOW_W'(cfg.debounce_ms);
  assign gt_long     = since_hold  > NOW_W'(cfg.long_press_ms);
  assign gt_gap      = since_phase > NOW_W'(cfg.double_gap_ms);

  always_comb begin
    nxt        = cur;
    event_code = EV_NONE;
    unique case (cur.phase)
      PH_IDLE: begin
        nxt.press_count = '0;
        if (pressed) begin
          nxt.phase       = PH_DEBOUNCE;
          nxt.phase_start = now_ms;
        end
      end
      PH_DEBOUNCE: begin
        if (gt_debounce) begin
          if (pressed) begin
            nxt.phase      = PH_PRESSED;
            nxt.hold_start = now_ms;
          end else begin
            nxt.phase = PH_IDLE;
          end
        end
      end
      PH_PRESSED: begin
        if (!pressed) begin
          if (cur.press_count != CNT_MAX) begin
            nxt.press_count = cur.press_count + CNT_W'(1);
          end
          nxt.phase       = PH_SHORT;
          nxt.phase_start = now_ms;
        end else if (gt_long) begin
          event_code = EV_LONG;
          nxt.phase  = PH_LONG;
        end
      end
      PH_SHORT: begin
        if (pressed && gt_debounce) begin
          nxt.phase       = PH_DEBOUNCE;
          nxt.phase_start = now_ms;
        end else if (gt_gap) begin
          // zero count stays here until a new press is debounced
          if (cur.press_count == CNT_W'(1)) begin
            nxt.phase = PH_SINGLE;
          end else if (cur.press_count > CNT_W'(1)) begin
            nxt.phase = PH_DOUBLE;
          end
        end
      end
      PH_LONG: begin
        if (!pressed) begin
          nxt.phase = PH_LONG_REL;
        end
      end
      PH_LONG_REL: begin
        event_code = EV_LONG_REL;
        nxt.phase  = PH_IDLE;
      end
      PH_SINGLE: begin
        event_code = EV_SINGLE;
        nxt.phase  = PH_IDLE;
      end
      PH_DOUBLE: begin
        event_code = EV_DOUBLE;
        nxt.phase  = PH_IDLE;
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

// File: sv/button_press_classifier.sv
// top level: input register, per-button state, step logic and result register
//
//  channel | direction | handshake              | payload
//  in_     | slave     | in_tvalid / in_tready   | in_tdata: button_sel, pin_level, now_ms
//  out_    | master    | out_tvalid / out_tready | out_tdata: button_echo, event_code
//  cfg_    | write     | cfg_wr_en               | cfg_index, cfg_wdata
//
// one poll per cycle sustained while results are not stalled; a result passes through the
// input register and then the result register around the single step stage.
// button state is read and written back in the step cycle, so polls of the same
// button may follow each other back to back.
// reset puts every button in idle with zero times and count, thresholds to defaults.
// a stalled result holds the step and the input register; in_tready drops only then.
module button_press_classifier import bpc_pkg::*; #(
  parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // button_sel[1:0], pin_level[2], now_ms[34:3]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // button_echo[1:0], event_code[4:2]
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_wdata
);

  // only the buttons that button_sel can reach need storage
  localparam int DEPTH = (NUM_BUTTONS < (1 << SEL_W)) ? NUM_BUTTONS : (1 << SEL_W);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cfg_t cfg;

  logic             in_v_r;
  logic [SEL_W-1:0] in_sel_r;
  logic             in_pin_r;
  logic [NOW_W-1:0] in_now_r;

  logic             out_v_r;
  logic [SEL_W-1:0] out_sel_r;
  logic [EV_W-1:0]  out_ev_r;

  btn_state_t [DEPTH-1:0] st_r;

  logic             advance;
  logic             step;
  logic             sel_ok;
  logic [IDX_W-1:0] idx;
  btn_state_t       cur;
  btn_state_t       nxt;
  logic [EV_W-1:0]  step_ev;
  logic [EV_W-1:0]  res_ev;

  bpc_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_wr_en),
    .wr_index (cfg_index),
    .wr_data  (cfg_wdata),
    .cfg      (cfg)
  );

  assign advance   = !out_v_r || out_tready;
  assign step      = in_v_r && advance;
  assign in_tready = !in_v_r || advance;

  assign sel_ok = 32'(in_sel_r) < DEPTH;
  assign idx    = IDX_W'(in_sel_r);
  assign cur    = st_r[idx];

  bpc_step u_step (
    .cur        (cur),
    .pressed    (!in_pin_r),
    .now_ms     (in_now_r),
    .cfg        (cfg),
    .nxt        (nxt),
    .event_code (step_ev)
  );

  // polls of absent buttons report nothing
  assign res_ev = sel_ok ? step_ev : EV_NONE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_sel_r <= in_tdata[SEL_W-1:0];
      in_pin_r <= in_tdata[SEL_W];
      in_now_r <= in_tdata[SEL_W+NOW_W:SEL_W+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        st_r[i].phase       <= PH_IDLE;
        st_r[i].phase_start <= '0;
        st_r[i].hold_start  <= '0;
        st_r[i].press_count <= '0;
      end
    end else if (step && sel_ok) begin
      st_r[idx] <= nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_sel_r <= in_sel_r;
      out_ev_r  <= res_ev;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(OUT_TDATA_W - SEL_W - EV_W){1'b0}}, out_ev_r, out_sel_r};

`ifndef SYNTHESIS
  a_step_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_v_r)
    else $error("result register not loaded after a step");

  a_state_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !(step && sel_ok) |=> $stable(st_r))
    else $error("button state changed without a step");

  a_absent_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !sel_ok) |=> (out_ev_r == EV_NONE))
    else $error("event reported for an absent button");

  a_long_from_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    (step && sel_ok && step_ev == EV_LONG) |-> (cur.phase == PH_PRESSED))
    else $error("long press reported outside the pressed phase");
`endif

endmodule
